// ===== hdl/i2cmrr_pkg.sv =====
// Shared types and constants for the I2C master combined register read block.
// Used by every module under hdl; depends on nothing else.

package i2cmrr_pkg;

  // Transfer phases. Each byte takes four consecutive codes: low, high, ack low, ack high.
  typedef enum logic [4:0] {
    PH_IDLE     = 5'd0,
    PH_ST_HI    = 5'd1,
    PH_ST_FALL  = 5'd2,
    PH_AW_0     = 5'd3,
    PH_AW_1     = 5'd4,
    PH_AW_2     = 5'd5,
    PH_AW_3     = 5'd6,
    PH_RG_0     = 5'd7,
    PH_RG_1     = 5'd8,
    PH_RG_2     = 5'd9,
    PH_RG_3     = 5'd10,
    PH_RS_LOW   = 5'd11,
    PH_RS_HIGH  = 5'd12,
    PH_RS_FALL  = 5'd13,
    PH_AR_0     = 5'd14,
    PH_AR_1     = 5'd15,
    PH_AR_2     = 5'd16,
    PH_AR_3     = 5'd17,
    PH_RX1_0    = 5'd18,
    PH_RX1_1    = 5'd19,
    PH_RX1_2    = 5'd20,
    PH_RX1_3    = 5'd21,
    PH_RX2_0    = 5'd22,
    PH_RX2_1    = 5'd23,
    PH_RX2_2    = 5'd24,
    PH_RX2_3    = 5'd25,
    PH_SP_LOW   = 5'd26,
    PH_SP_HIGH  = 5'd27,
    PH_SP_END   = 5'd28,
    PH_SPE_LOW  = 5'd29,
    PH_SPE_HIGH = 5'd30,
    PH_SPE_END  = 5'd31
  } phase_t;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_READ1 = 2'd1,
    ACT_READ2 = 2'd2,
    ACT_SPARE = 2'd3
  } action_t;

  localparam logic [1:0] CFG_HALF_PERIOD = 2'd0;
  localparam logic [1:0] CFG_STRETCH_TO  = 2'd1;
  localparam logic [1:0] CFG_DEV_ADDR    = 2'd2;

  localparam logic [7:0] HALF_PERIOD_RESET = 8'd5;
  localparam int         TIMEOUT_RESET     = 100;
  localparam logic [6:0] DEV_ADDR_RESET    = 7'd85;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] reg_addr;
    logic       sda_in;
    logic       scl_in;
  } in_item_t;

  typedef struct packed {
    logic        scl_out;
    logic        sda_out;
    logic        busy_res;
    logic        done_res;
    logic        ack_error;
    logic [15:0] read_data;
  } out_item_t;

endpackage

// ===== hdl/i2cmrr_cfg.sv =====
// Configuration registers: half period, clock stretch timeout and device address.
// Depends on i2cmrr_pkg for register indexes and reset values.

module i2cmrr_cfg #(
  parameter int TIMEOUT_BITS = 10,
  parameter int CFG_W        = 10
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [1:0]              cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  output logic [7:0]              half_period,
  output logic [TIMEOUT_BITS-1:0] stretch_timeout,
  output logic [6:0]              dev_addr
);

  localparam logic [TIMEOUT_BITS-1:0] TO_RESET = TIMEOUT_BITS'(i2cmrr_pkg::TIMEOUT_RESET);

  logic [7:0]              half_r,    half_nxt;
  logic [TIMEOUT_BITS-1:0] timeout_r, timeout_nxt;
  logic [6:0]              addr_r,    addr_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    half_nxt    = half_r;
    timeout_nxt = timeout_r;
    addr_nxt    = addr_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        i2cmrr_pkg::CFG_HALF_PERIOD: half_nxt    = cfg_data[7:0];
        i2cmrr_pkg::CFG_STRETCH_TO:  timeout_nxt = cfg_data[TIMEOUT_BITS-1:0];
        i2cmrr_pkg::CFG_DEV_ADDR:    addr_nxt    = cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r    <= i2cmrr_pkg::HALF_PERIOD_RESET;
      timeout_r <= TO_RESET;
      addr_r    <= i2cmrr_pkg::DEV_ADDR_RESET;
    end else begin
      half_r    <= half_nxt;
      timeout_r <= timeout_nxt;
      addr_r    <= addr_nxt;
    end
  end

  assign half_period     = half_r;
  assign stretch_timeout = timeout_r;
  assign dev_addr        = addr_r;

endmodule

// ===== hdl/i2cmrr_core.sv =====
// Transfer sequencer: phase register, timers, shift register and read data.
// Each accepted tick advances the state once. Depends on i2cmrr_pkg.

module i2cmrr_core #(
  parameter int TIMEOUT_BITS = 10
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_fire,
  input  i2cmrr_pkg::in_item_t    item,
  input  logic [7:0]              half_period,
  input  logic [TIMEOUT_BITS-1:0] stretch_timeout,
  input  logic [6:0]              dev_addr,
  output i2cmrr_pkg::out_item_t   result
);

  i2cmrr_pkg::phase_t      phase_r, phase_nxt;
  logic [7:0]              timer_r, timer_nxt;
  logic [TIMEOUT_BITS-1:0] stretch_r, stretch_nxt;
  logic [3:0]              bc_r, bc_nxt;
  logic [7:0]              shift_r, shift_nxt;
  logic [7:0]              latched_r, latched_nxt;
  logic                    word_r, word_nxt;
  logic [15:0]             data_r, data_nxt;

  logic       stretch_ph;
  logic       hold;
  logic       ph_end;
  logic       enter;
  logic [7:0] h_eff;
  logic [7:0] timer_inc;
  logic [3:0] bc_inc;
  logic [7:0] rx_shift;
  logic       scl_drv, sda_drv, done, err;
  logic       start_req;

  assign h_eff     = (half_period == 8'd0) ? 8'd1 : half_period;
  assign timer_inc = timer_r + 8'd1;
  assign bc_inc    = bc_r + 4'd1;
  assign rx_shift  = {shift_r[6:0], item.sda_in};
  assign start_req = (item.action == i2cmrr_pkg::ACT_READ1) ||
                     (item.action == i2cmrr_pkg::ACT_READ2);

  // Clocked high phases wait for SCL to read high before the phase timer runs, up to the stretch timeout.
  always_comb begin
    unique case (phase_r) inside
      i2cmrr_pkg::PH_AW_1, i2cmrr_pkg::PH_AW_3, i2cmrr_pkg::PH_RG_1, i2cmrr_pkg::PH_RG_3,
      i2cmrr_pkg::PH_AR_1, i2cmrr_pkg::PH_AR_3, i2cmrr_pkg::PH_RX1_1, i2cmrr_pkg::PH_RX1_3,
      i2cmrr_pkg::PH_RX2_1, i2cmrr_pkg::PH_RX2_3, i2cmrr_pkg::PH_RS_HIGH:
        stretch_ph = 1'b1;
      default:
        stretch_ph = 1'b0;
    endcase
  end

  assign hold   = stretch_ph && (timer_r == 8'd0) && !item.scl_in &&
                  (stretch_r < stretch_timeout);
  assign ph_end = !hold && (timer_inc >= h_eff);

  // Line drive during this tick follows the current phase, the shift register's top bit and the two-byte flag.
  always_comb begin
    unique case (phase_r) inside
      i2cmrr_pkg::PH_AW_0, i2cmrr_pkg::PH_RG_0, i2cmrr_pkg::PH_AR_0: begin
        scl_drv = 1'b0; sda_drv = shift_r[7];
      end
      i2cmrr_pkg::PH_AW_1, i2cmrr_pkg::PH_RG_1, i2cmrr_pkg::PH_AR_1: begin
        scl_drv = 1'b1; sda_drv = shift_r[7];
      end
      i2cmrr_pkg::PH_AW_2, i2cmrr_pkg::PH_RG_2, i2cmrr_pkg::PH_AR_2,
      i2cmrr_pkg::PH_RX1_0, i2cmrr_pkg::PH_RX2_0: begin
        scl_drv = 1'b0; sda_drv = 1'b1;
      end
      i2cmrr_pkg::PH_RX1_2: begin
        scl_drv = 1'b0; sda_drv = !word_r;
      end
      i2cmrr_pkg::PH_RX1_3: begin
        scl_drv = 1'b1; sda_drv = !word_r;
      end
      i2cmrr_pkg::PH_RX2_2: begin
        scl_drv = 1'b0; sda_drv = 1'b1;
      end
      i2cmrr_pkg::PH_ST_FALL, i2cmrr_pkg::PH_RS_FALL, i2cmrr_pkg::PH_SP_HIGH,
      i2cmrr_pkg::PH_SPE_HIGH: begin
        scl_drv = 1'b1; sda_drv = 1'b0;
      end
      i2cmrr_pkg::PH_RS_LOW: begin
        scl_drv = 1'b0; sda_drv = 1'b1;
      end
      i2cmrr_pkg::PH_SP_LOW, i2cmrr_pkg::PH_SPE_LOW: begin
        scl_drv = 1'b0; sda_drv = 1'b0;
      end
      default: begin
        scl_drv = 1'b1; sda_drv = 1'b1;
      end
    endcase
  end

  always_comb begin
    phase_nxt   = phase_r;
    timer_nxt   = timer_r;
    stretch_nxt = stretch_r;
    bc_nxt      = bc_r;
    shift_nxt   = shift_r;
    latched_nxt = latched_r;
    word_nxt    = word_r;
    data_nxt    = data_r;
    done        = 1'b0;
    err         = 1'b0;
    enter       = 1'b0;

    if (phase_r != i2cmrr_pkg::PH_IDLE) begin
      if (hold) begin
        stretch_nxt = stretch_r + {{(TIMEOUT_BITS-1){1'b0}}, 1'b1};
      end else begin
        timer_nxt = timer_inc;
      end
    end

    unique case (phase_r) inside
      i2cmrr_pkg::PH_IDLE: begin
        if (start_req) begin
          latched_nxt = item.reg_addr;
          word_nxt    = (item.action == i2cmrr_pkg::ACT_READ2);
          data_nxt    = 16'd0;
          phase_nxt   = i2cmrr_pkg::PH_ST_HI;
          enter       = 1'b1;
        end
      end
      i2cmrr_pkg::PH_ST_HI, i2cmrr_pkg::PH_RS_LOW, i2cmrr_pkg::PH_RS_HIGH,
      i2cmrr_pkg::PH_AW_0, i2cmrr_pkg::PH_AW_2, i2cmrr_pkg::PH_RG_0, i2cmrr_pkg::PH_RG_2,
      i2cmrr_pkg::PH_AR_0, i2cmrr_pkg::PH_AR_2, i2cmrr_pkg::PH_RX1_0, i2cmrr_pkg::PH_RX1_2,
      i2cmrr_pkg::PH_RX2_0, i2cmrr_pkg::PH_RX2_2, i2cmrr_pkg::PH_SP_LOW,
      i2cmrr_pkg::PH_SP_HIGH, i2cmrr_pkg::PH_SPE_LOW, i2cmrr_pkg::PH_SPE_HIGH: begin
        if (ph_end) begin
          phase_nxt = i2cmrr_pkg::phase_t'(phase_r + 5'd1);
          enter     = 1'b1;
        end
      end
      i2cmrr_pkg::PH_ST_FALL: begin
        if (ph_end) begin
          phase_nxt = i2cmrr_pkg::PH_AW_0;
          shift_nxt = {dev_addr, 1'b0};
          bc_nxt    = 4'd0;
          enter     = 1'b1;
        end
      end
      i2cmrr_pkg::PH_RS_FALL: begin
        if (ph_end) begin
          phase_nxt = i2cmrr_pkg::PH_AR_0;
          shift_nxt = {dev_addr, 1'b1};
          bc_nxt    = 4'd0;
          enter     = 1'b1;
        end
      end
      i2cmrr_pkg::PH_AW_1, i2cmrr_pkg::PH_RG_1, i2cmrr_pkg::PH_AR_1: begin
        // After the eighth bit the ack slot follows, else back to the low phase.
        if (ph_end) begin
          shift_nxt = {shift_r[6:0], 1'b0};
          bc_nxt    = bc_inc;
          phase_nxt = (bc_inc >= 4'd8) ? i2cmrr_pkg::phase_t'(phase_r + 5'd1)
                                       : i2cmrr_pkg::phase_t'(phase_r - 5'd1);
          enter     = 1'b1;
        end
      end
      i2cmrr_pkg::PH_AW_3: begin
        if (ph_end) begin
          enter = 1'b1;
          if (item.sda_in) begin
            phase_nxt = i2cmrr_pkg::PH_SPE_LOW;
          end else begin
            phase_nxt = i2cmrr_pkg::PH_RG_0;
            shift_nxt = latched_r;
            bc_nxt    = 4'd0;
          end
        end
      end
      i2cmrr_pkg::PH_RG_3: begin
        if (ph_end) begin
          enter     = 1'b1;
          phase_nxt = item.sda_in ? i2cmrr_pkg::PH_SPE_LOW : i2cmrr_pkg::PH_RS_LOW;
        end
      end
      i2cmrr_pkg::PH_AR_3: begin
        if (ph_end) begin
          enter = 1'b1;
          if (item.sda_in) begin
            phase_nxt = i2cmrr_pkg::PH_SPE_LOW;
          end else begin
            phase_nxt = i2cmrr_pkg::PH_RX1_0;
            shift_nxt = 8'd0;
            bc_nxt    = 4'd0;
          end
        end
      end
      i2cmrr_pkg::PH_RX1_1, i2cmrr_pkg::PH_RX2_1: begin
        if (ph_end) begin
          shift_nxt = rx_shift;
          bc_nxt    = bc_inc;
          enter     = 1'b1;
          if (bc_inc >= 4'd8) begin
            if (phase_r == i2cmrr_pkg::PH_RX1_1) begin
              data_nxt = {8'd0, rx_shift};
            end else begin
              data_nxt = {data_r[15:8] | rx_shift, data_r[7:0]};
            end
            phase_nxt = i2cmrr_pkg::phase_t'(phase_r + 5'd1);
          end else begin
            phase_nxt = i2cmrr_pkg::phase_t'(phase_r - 5'd1);
          end
        end
      end
      i2cmrr_pkg::PH_RX1_3: begin
        if (ph_end) begin
          enter = 1'b1;
          if (word_r) begin
            phase_nxt = i2cmrr_pkg::PH_RX2_0;
            shift_nxt = 8'd0;
            bc_nxt    = 4'd0;
          end else begin
            phase_nxt = i2cmrr_pkg::PH_SP_LOW;
          end
        end
      end
      i2cmrr_pkg::PH_RX2_3: begin
        if (ph_end) begin
          enter     = 1'b1;
          phase_nxt = i2cmrr_pkg::PH_SP_LOW;
        end
      end
      i2cmrr_pkg::PH_SP_END, i2cmrr_pkg::PH_SPE_END: begin
        if (ph_end) begin
          done      = 1'b1;
          err       = (phase_r == i2cmrr_pkg::PH_SPE_END);
          phase_nxt = i2cmrr_pkg::PH_IDLE;
          enter     = 1'b1;
        end
      end
      default: begin
        phase_nxt = i2cmrr_pkg::PH_IDLE;
        enter     = 1'b1;
      end
    endcase

    if (enter) begin
      timer_nxt   = 8'd0;
      stretch_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= i2cmrr_pkg::PH_IDLE;
      timer_r   <= 8'd0;
      stretch_r <= '0;
      bc_r      <= 4'd0;
      shift_r   <= 8'd0;
      latched_r <= 8'd0;
      word_r    <= 1'b0;
      data_r    <= 16'd0;
    end else if (in_fire) begin
      phase_r   <= phase_nxt;
      timer_r   <= timer_nxt;
      stretch_r <= stretch_nxt;
      bc_r      <= bc_nxt;
      shift_r   <= shift_nxt;
      latched_r <= latched_nxt;
      word_r    <= word_nxt;
      data_r    <= data_nxt;
    end
  end

  always_comb begin
    result.scl_out   = scl_drv;
    result.sda_out   = sda_drv;
    result.busy_res  = (phase_nxt != i2cmrr_pkg::PH_IDLE);
    result.done_res  = done;
    result.ack_error = err;
    result.read_data = data_nxt;
  end

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && result.done_res |-> !result.busy_res)
    else $error("transfer finished but still reported busy");

  a_err_with_done: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && result.ack_error |-> result.done_res)
    else $error("ack error flagged without transfer end");

  a_start_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (phase_r == i2cmrr_pkg::PH_IDLE) && start_req
    |=> phase_r == i2cmrr_pkg::PH_ST_HI)
    else $error("start request from idle did not begin the START setup");

  a_bit_count: assert property (@(posedge clk) disable iff (!rst_n)
    bc_r <= 4'd8)
    else $error("bit counter ran past one byte");

endmodule

// ===== hdl/i2cmrr_out.sv =====
// Result register between the sequencer and the result channel.
// Holds one result while stalled and takes a new one as the old one leaves.

module i2cmrr_out (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  in_fire,
  input  i2cmrr_pkg::out_item_t result,
  output logic                  out_valid,
  input  logic                  out_stall,
  output i2cmrr_pkg::out_item_t out_data
);

  logic                  valid_r, valid_nxt;
  i2cmrr_pkg::out_item_t data_r, data_nxt;

  // A new request is taken whenever the register is empty or being emptied.
  assign in_stall = valid_r && out_stall;
  assign in_fire  = in_valid && !in_stall;

  always_comb begin
    valid_nxt = in_fire || (valid_r && out_stall);
    data_nxt  = in_fire ? result : data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== hdl/i2c_master_register_read.sv =====
// Top level of the I2C master combined register read block.
// Instantiates i2cmrr_cfg, i2cmrr_core and i2cmrr_out; types from i2cmrr_pkg.
//
//  channel   direction  handshake          payload
//  in_       input      valid / stall      i2cmrr_pkg::in_item_t (one tick, pin samples)
//  out_      output     valid / stall      i2cmrr_pkg::out_item_t (line drive, status, data)
//  cfg_      input      valid / ready      index and data of one register write
//
// One request is taken per clock cycle while the input side does not stall; its result
// appears in the result register on the next cycle, computed combinationally by the phase sequencer.
// Reset is synchronous and active low; it returns the sequencer to idle and the
// registers to their reset values. The input side stalls only while a result is
// held and the result side stalls. Configuration writes are always ready.

module i2c_master_register_read #(
  parameter int TIMEOUT_BITS = 10,
  parameter int CFG_W        = (TIMEOUT_BITS > 8) ? TIMEOUT_BITS : 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  i2cmrr_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output i2cmrr_pkg::out_item_t out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  logic [7:0]              half_period;
  logic [TIMEOUT_BITS-1:0] stretch_timeout;
  logic [6:0]              dev_addr;
  logic                    in_fire;
  i2cmrr_pkg::out_item_t   result;

  i2cmrr_cfg #(
    .TIMEOUT_BITS(TIMEOUT_BITS),
    .CFG_W       (CFG_W)
  ) u_cfg (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .half_period    (half_period),
    .stretch_timeout(stretch_timeout),
    .dev_addr       (dev_addr)
  );

  i2cmrr_core #(
    .TIMEOUT_BITS(TIMEOUT_BITS)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_fire        (in_fire),
    .item           (in_data),
    .half_period    (half_period),
    .stretch_timeout(stretch_timeout),
    .dev_addr       (dev_addr),
    .result         (result)
  );

  i2cmrr_out u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_fire  (in_fire),
    .result   (result),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for i2c_master_register_read: a responding I2C target drives the pin samples,
// and a tick-accurate predictor of the master checks every result. Depends on i2cmrr_pkg.

module tb_top;
  import i2cmrr_pkg::*;

  localparam int CFG_W          = 10;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int HOLD_CYCLES    = 200;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  // Where the responding target withholds its acknowledge.
  typedef enum int {
    NACK_NONE       = 0,
    NACK_WRITE_ADDR = 1,
    NACK_REGISTER   = 2,
    NACK_READ_ADDR  = 3
  } nack_point_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_stall;
  out_item_t        out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [1:0]       cfg_index;
  logic [CFG_W-1:0] cfg_data;

  i2c_master_register_read uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predicted state of the master and its register copies.
  phase_t      cur_phase;
  logic [7:0]  phase_ticks;
  logic [9:0]  stretch_ticks;
  logic [3:0]  bits_done;
  logic [7:0]  shift_reg;
  logic [7:0]  reg_byte;
  logic        two_bytes;
  logic [15:0] word_read;
  logic [7:0]  half_ticks;
  logic [9:0]  stretch_limit;
  logic [6:0]  dev_addr;

  // Behaviour of the responding target for the current transfer.
  nack_point_t tgt_nack;
  logic [15:0] tgt_data;
  int          tgt_stretch;
  int          tgt_noise;

  out_item_t   tick_outcomes[$];
  bit          sender_quiet;
  bit          receiver_quiet;
  int          hold_request;
  int          ticks_sent;
  int          results_checked;
  int          failures;
  int          transfers_done;
  int          transfers_failed;
  out_item_t   want;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void reset_model();
    cur_phase     = PH_IDLE;
    phase_ticks   = '0;
    stretch_ticks = '0;
    bits_done     = '0;
    shift_reg     = '0;
    reg_byte      = '0;
    two_bytes     = 1'b0;
    word_read     = '0;
    half_ticks    = HALF_PERIOD_RESET;
    stretch_limit = 10'(TIMEOUT_RESET);
    dev_addr      = DEV_ADDR_RESET;
  endfunction

  function automatic void enter_phase(phase_t p);
    cur_phase     = p;
    phase_ticks   = '0;
    stretch_ticks = '0;
  endfunction

  function automatic void load_phase(phase_t p, logic [7:0] value);
    enter_phase(p);
    shift_reg = value;
    bits_done = '0;
  endfunction

  function automatic phase_t tx_base(phase_t p);
    if (p >= PH_AW_0 && p <= PH_AW_3) return PH_AW_0;
    if (p >= PH_RG_0 && p <= PH_RG_3) return PH_RG_0;
    if (p >= PH_AR_0 && p <= PH_AR_3) return PH_AR_0;
    return PH_IDLE;
  endfunction

  function automatic phase_t rx_base(phase_t p);
    if (p >= PH_RX1_0 && p <= PH_RX1_3) return PH_RX1_0;
    if (p >= PH_RX2_0 && p <= PH_RX2_3) return PH_RX2_0;
    return PH_IDLE;
  endfunction

  // One tick of the current phase; true on the tick that ends it. A clocked high phase
  // holds at its first tick while SCL reads low, up to the stretch limit.
  function automatic logic phase_tick(logic stretchable, logic scl);
    logic [7:0] limit;
    limit = (half_ticks == 8'd0) ? 8'd1 : half_ticks;
    if (stretchable && phase_ticks == 8'd0 && !scl && stretch_ticks < stretch_limit) begin
      stretch_ticks = stretch_ticks + 10'd1;
      return 1'b0;
    end
    phase_ticks = phase_ticks + 8'd1;
    return phase_ticks >= limit;
  endfunction

  // Returns {scl, sda} as driven during the current phase.
  function automatic logic [1:0] line_drive(phase_t tb, phase_t rb);
    logic [4:0] off;
    if (tb != PH_IDLE) begin
      off = cur_phase - tb;
      return {off[0], (off < 5'd2) ? shift_reg[7] : 1'b1};
    end
    if (rb != PH_IDLE) begin
      off = cur_phase - rb;
      return {off[0], (off < 5'd2) ? 1'b1 : !(rb == PH_RX1_0 && two_bytes)};
    end
    case (cur_phase)
      PH_ST_FALL, PH_RS_FALL, PH_SP_HIGH, PH_SPE_HIGH: return 2'b10;
      PH_RS_LOW: return 2'b01;
      PH_SP_LOW, PH_SPE_LOW: return 2'b00;
      default: return 2'b11;
    endcase
  endfunction

  function automatic out_item_t step_master(in_item_t it);
    out_item_t  r;
    phase_t     tb;
    phase_t     rb;
    logic [4:0] off;
    logic       done;
    logic       err;
    done = 1'b0;
    err  = 1'b0;
    tb   = tx_base(cur_phase);
    rb   = rx_base(cur_phase);
    {r.scl_out, r.sda_out} = line_drive(tb, rb);
    if (tb != PH_IDLE) begin
      off = cur_phase - tb;
      case (off)
        5'd0: begin
          if (phase_tick(1'b0, it.scl_in)) enter_phase(phase_t'(tb + 1));
        end
        5'd1: begin
          if (phase_tick(1'b1, it.scl_in)) begin
            shift_reg = shift_reg << 1;
            bits_done = bits_done + 4'd1;
            enter_phase((bits_done >= 4'd8) ? phase_t'(tb + 2) : tb);
          end
        end
        5'd2: begin
          if (phase_tick(1'b0, it.scl_in)) enter_phase(phase_t'(tb + 3));
        end
        default: begin
          if (phase_tick(1'b1, it.scl_in)) begin
            if (it.sda_in) enter_phase(PH_SPE_LOW);
            else if (tb == PH_AW_0) load_phase(PH_RG_0, reg_byte);
            else if (tb == PH_RG_0) enter_phase(PH_RS_LOW);
            else load_phase(PH_RX1_0, 8'h00);
          end
        end
      endcase
    end else if (rb != PH_IDLE) begin
      off = cur_phase - rb;
      case (off)
        5'd0, 5'd2: begin
          if (phase_tick(1'b0, it.scl_in)) enter_phase(phase_t'(cur_phase + 1));
        end
        5'd1: begin
          if (phase_tick(1'b1, it.scl_in)) begin
            shift_reg = {shift_reg[6:0], it.sda_in};
            bits_done = bits_done + 4'd1;
            if (bits_done >= 4'd8) begin
              if (rb == PH_RX1_0) word_read = {8'h00, shift_reg};
              else word_read = word_read | {shift_reg, 8'h00};
              enter_phase(phase_t'(rb + 2));
            end else begin
              enter_phase(rb);
            end
          end
        end
        default: begin
          if (phase_tick(1'b1, it.scl_in)) begin
            if (rb == PH_RX1_0 && two_bytes) load_phase(PH_RX2_0, 8'h00);
            else enter_phase(PH_SP_LOW);
          end
        end
      endcase
    end else begin
      case (cur_phase)
        PH_IDLE: begin
          if (it.action == ACT_READ1 || it.action == ACT_READ2) begin
            reg_byte  = it.reg_addr;
            two_bytes = (it.action == ACT_READ2);
            word_read = '0;
            enter_phase(PH_ST_HI);
          end
        end
        PH_ST_HI: begin
          if (phase_tick(1'b0, it.scl_in)) enter_phase(PH_ST_FALL);
        end
        PH_ST_FALL: begin
          if (phase_tick(1'b0, it.scl_in)) load_phase(PH_AW_0, {dev_addr, 1'b0});
        end
        PH_RS_LOW: begin
          if (phase_tick(1'b0, it.scl_in)) enter_phase(PH_RS_HIGH);
        end
        PH_RS_HIGH: begin
          if (phase_tick(1'b1, it.scl_in)) enter_phase(PH_RS_FALL);
        end
        PH_RS_FALL: begin
          if (phase_tick(1'b0, it.scl_in)) load_phase(PH_AR_0, {dev_addr, 1'b1});
        end
        PH_SP_LOW, PH_SP_HIGH, PH_SPE_LOW, PH_SPE_HIGH: begin
          if (phase_tick(1'b0, it.scl_in)) enter_phase(phase_t'(cur_phase + 1));
        end
        PH_SP_END, PH_SPE_END: begin
          if (phase_tick(1'b0, it.scl_in)) begin
            done = 1'b1;
            err  = (cur_phase == PH_SPE_END);
            enter_phase(PH_IDLE);
          end
        end
        default: enter_phase(PH_IDLE);
      endcase
    end
    r.busy_res  = (cur_phase != PH_IDLE);
    r.done_res  = done;
    r.ack_error = err;
    r.read_data = word_read;
    return r;
  endfunction

  // Pin samples a well-behaved target would present in the current phase, with optional
  // stretching of SCL and random disturbance of SDA.
  function automatic in_item_t target_response(logic [1:0] act, logic [7:0] regb);
    in_item_t   it;
    phase_t     tb;
    phase_t     rb;
    logic [4:0] off;
    logic       stretchable;
    tb = tx_base(cur_phase);
    rb = rx_base(cur_phase);
    off = (tb != PH_IDLE) ? 5'(cur_phase - tb) : 5'(cur_phase - rb);
    stretchable = ((tb != PH_IDLE || rb != PH_IDLE) && off[0]) || cur_phase == PH_RS_HIGH;
    it.action   = act;
    it.reg_addr = regb;
    it.sda_in   = 1'($urandom_range(0, 1));
    if (stretchable && phase_ticks == 8'd0) it.scl_in = !(int'(stretch_ticks) < tgt_stretch);
    else it.scl_in = 1'($urandom_range(0, 1));
    if (tb != PH_IDLE && off == 5'd3) begin
      it.sda_in = (tb == PH_AW_0 && tgt_nack == NACK_WRITE_ADDR) ||
                  (tb == PH_RG_0 && tgt_nack == NACK_REGISTER) ||
                  (tb == PH_AR_0 && tgt_nack == NACK_READ_ADDR);
    end else if (rb != PH_IDLE && off == 5'd1) begin
      it.sda_in = tgt_data[((rb == PH_RX1_0) ? 7 : 15) - int'(bits_done)];
    end
    if ($urandom_range(0, 99) < tgt_noise) it.sda_in = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // Called at a falling edge; returns at the falling edge after the request is taken,
  // leaving valid high so that a following request can go out without a gap.
  task automatic send_tick(in_item_t it);
    int        gap;
    out_item_t r;
    gap = sender_quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = step_master(it);
    tick_outcomes.push_back(r);
    ticks_sent++;
    if (r.done_res) begin
      transfers_done++;
      if (r.ack_error) transfers_failed++;
    end
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (tick_outcomes.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_HALF_PERIOD: half_ticks = value[7:0];
      CFG_STRETCH_TO:  stretch_limit = value[9:0];
      CFG_DEV_ADDR:    dev_addr = value[6:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_bus(logic [CFG_W-1:0] half, logic [CFG_W-1:0] timeout,
                         logic [CFG_W-1:0] addr);
    wait_drained();
    repeat (4) @(negedge clk);
    write_reg(CFG_HALF_PERIOD, half);
    write_reg(CFG_STRETCH_TO, timeout);
    write_reg(CFG_DEV_ADDR, addr);
  endtask

  task automatic idle_ticks(int n);
    repeat (n) send_tick(target_response($urandom_range(0, 1) ? ACT_SPARE : ACT_TICK,
                                         8'($urandom_range(0, 255))));
  endtask

  // Starts a read from idle and ticks until the master is idle again. While busy the
  // action field is random, so starts arriving mid-transfer are exercised throughout.
  task automatic run_transfer(action_t act, logic [7:0] regb, logic [15:0] data,
                              nack_point_t nack, int stretch, int noise);
    tgt_nack    = nack;
    tgt_data    = data;
    tgt_stretch = stretch;
    tgt_noise   = noise;
    send_tick(target_response(act, regb));
    while (cur_phase != PH_IDLE) begin
      send_tick(target_response(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255))));
    end
  endtask

  task automatic test_reset_defaults();
    idle_ticks(3);
    run_transfer(ACT_READ1, 8'h5A, 16'h00C3, NACK_NONE, 0, 0);
    idle_ticks(2);
  endtask

  task automatic test_register_extremes();
    // Upper bits of the half period and device address writes are beyond the register and must be dropped.
    set_bus(10'h101, 10'h3FF, 10'h3FF);
    write_reg(CFG_UNUSED, 10'h2AA);
    run_transfer(ACT_READ2, 8'hFF, 16'hFFFF, NACK_NONE, 0, 0);
    set_bus(10'h001, 10'h000, 10'h000);
    run_transfer(ACT_READ2, 8'h00, 16'h0000, NACK_NONE, 0, 0);
    run_transfer(ACT_READ1, 8'h80, 16'hFF01, NACK_NONE, 0, 0);
    run_transfer(ACT_READ2, 8'h01, 16'h0180, NACK_NONE, 0, 0);
  endtask

  task automatic test_missing_ack();
    set_bus(10'd1, 10'd100, 10'h2B);
    run_transfer(ACT_READ2, 8'h3C, 16'h1234, NACK_WRITE_ADDR, 0, 0);
    run_transfer(ACT_READ2, 8'hC3, 16'h5678, NACK_REGISTER, 0, 0);
    run_transfer(ACT_READ1, 8'h96, 16'h9ABC, NACK_READ_ADDR, 0, 0);
    run_transfer(ACT_READ1, 8'h69, 16'h00EE, NACK_NONE, 0, 0);
  endtask

  task automatic test_half_period_zero();
    set_bus(10'h300, 10'd100, 10'h55);
    run_transfer(ACT_READ2, 8'hA5, 16'hBEEF, NACK_NONE, 0, 0);
  endtask

  task automatic test_clock_stretch();
    // Targets holding SCL longer than the limit, where the master carries on regardless, and one within it.
    set_bus(10'd2, 10'd3, 10'h11);
    run_transfer(ACT_READ2, 8'h42, 16'hC0DE, NACK_NONE, 10, 0);
    set_bus(10'd2, 10'd0, 10'h12);
    run_transfer(ACT_READ1, 8'h24, 16'h0071, NACK_NONE, 6, 0);
    set_bus(10'd2, 10'd1023, 10'h13);
    run_transfer(ACT_READ2, 8'h18, 16'h8001, NACK_NONE, 9, 0);
  endtask

  task automatic test_slowest_clock();
    set_bus(10'd255, 10'd100, 10'h7F);
    sender_quiet   = 1'b1;
    receiver_quiet = 1'b1;
    run_transfer(ACT_READ1, 8'h7E, 16'h00A5, NACK_NONE, 2, 0);
    sender_quiet   = 1'b0;
    receiver_quiet = 1'b0;
  endtask

  task automatic test_backpressure();
    set_bus(10'd1, 10'd100, 10'h50);
    // The receiver stops taking results while requests keep coming without gaps.
    sender_quiet = 1'b1;
    hold_request = HOLD_CYCLES;
    run_transfer(ACT_READ2, 8'h5C, 16'h3366, NACK_NONE, 3, 0);
    sender_quiet = 1'b0;
    wait_drained();
    run_transfer(ACT_READ1, 8'hC5, 16'h00F0, NACK_NONE, 0, 0);
  endtask

  task automatic test_random_traffic();
    int          round_start;
    int          pick;
    logic [7:0]  half;
    nack_point_t nack;
    for (int pass_no = 0; pass_no < 8; pass_no++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) half = 8'd0;
      else if (pick <= 6) half = 8'd1;
      else if (pick <= 8) half = 8'($urandom_range(2, 4));
      else half = 8'($urandom_range(5, 8));
      set_bus({2'($urandom_range(0, 3)), half},
              $urandom_range(0, 1) ? 10'($urandom_range(0, 15)) : 10'($urandom_range(0, 1023)),
              10'($urandom_range(0, 1023)));
      if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, 10'($urandom_range(0, 1023)));
      sender_quiet   = (pass_no == 3);
      receiver_quiet = (pass_no == 3 || pass_no == 6);
      round_start    = ticks_sent;
      while (ticks_sent - round_start < 110) begin
        idle_ticks($urandom_range(0, 3));
        nack = ($urandom_range(0, 9) < 7) ? NACK_NONE : nack_point_t'($urandom_range(1, 3));
        run_transfer($urandom_range(0, 1) ? ACT_READ2 : ACT_READ1,
                     8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), nack,
                     ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 12),
                     ($urandom_range(0, 9) == 0) ? 15 : 0);
      end
    end
    sender_quiet   = 1'b0;
    receiver_quiet = 1'b0;
  endtask

  // Receiver: a random stall before each result, or a long hold-off when one is asked for.
  initial begin : result_stall
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        n = hold_request;
        hold_request = 0;
      end else begin
        n = receiver_quiet ? 0 : $urandom_range(0, 8);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!(rst_n && out_valid && !out_stall)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (tick_outcomes.size() == 0) begin
        failures++;
        if (failures <= 10) $display("Result with no request outstanding: %p", out_data);
      end else begin
        want = tick_outcomes.pop_front();
        results_checked++;
        if (out_data.scl_out !== want.scl_out || out_data.sda_out !== want.sda_out ||
            out_data.busy_res !== want.busy_res || out_data.done_res !== want.done_res ||
            out_data.ack_error !== want.ack_error || out_data.read_data !== want.read_data) begin
          failures++;
          if (failures <= 10) begin
            $display("Mismatch on result %0d: expected scl=%0b sda=%0b busy=%0b done=%0b err=%0b data=%04h",
                     results_checked, want.scl_out, want.sda_out, want.busy_res,
                     want.done_res, want.ack_error, want.read_data);
            $display("                      actual   scl=%0b sda=%0b busy=%0b done=%0b err=%0b data=%04h",
                     out_data.scl_out, out_data.sda_out, out_data.busy_res,
                     out_data.done_res, out_data.ack_error, out_data.read_data);
          end
        end
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("No request moved for %0d cycles; %0d results still outstanding.",
             WATCHDOG_LIMIT, tick_outcomes.size());
    $display("Some tests failed");
    $finish;
  end

  initial begin
    in_valid       = 1'b0;
    in_data        = '0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    sender_quiet   = 1'b0;
    receiver_quiet = 1'b0;
    hold_request   = 0;
    tgt_nack       = NACK_NONE;
    tgt_data       = '0;
    tgt_stretch    = 0;
    tgt_noise      = 0;
    rst_n          = 1'b0;
    reset_model();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_register_extremes();
    test_missing_ack();
    test_half_period_zero();
    test_clock_stretch();
    test_slowest_clock();
    test_backpressure();
    test_random_traffic();

    wait_drained();
    repeat (5) @(posedge clk);
    if (tick_outcomes.size() != 0) failures++;
    $display("Checked %0d results from %0d ticks over %0d transfers, %0d ending on a missing ACK,",
             results_checked, ticks_sent, transfers_done, transfers_failed);
    $display("with register extremes, clock stretching, starts while busy and a long result hold-off.");
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d failures in total.", failures);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
